### hdl/lpfd_pkg.sv
// Shared constants and controller/datapath interface types for the frame deframer.
package lpfd_pkg;

    // Largest accepted length (command byte plus payload bytes).
    localparam int MAX_FRAME_LEN = 32;
    localparam int STORE_DEPTH   = MAX_FRAME_LEN - 1;

    localparam int BYTE_W = 8;
    localparam int PLEN_W = 5;                              // payload_len port width
    localparam int WP_W   = $clog2(MAX_FRAME_LEN);          // payload position / count
    localparam int LEN_W  = $clog2(MAX_FRAME_LEN + 1);      // remaining byte count

    localparam logic [BYTE_W-1:0] LEN_EXT_MASK = 8'h80;
    localparam logic [BYTE_W-1:0] LEN_LOW_MASK = 8'h7F;
    localparam logic [BYTE_W-1:0] MAX_LEN_B    = BYTE_W'(MAX_FRAME_LEN);

    // Controller -> datapath commands.
    typedef struct packed {
        logic xor_load;    // running check = rx byte
        logic xor_acc;     // running check ^= rx byte
        logic hi_load;     // capture high length bits
        logic start1;      // start frame with one-byte length
        logic start2;      // start frame with two-byte length
        logic cmd_load;    // capture command byte
        logic data_write;  // store payload byte
        logic rem_dec;     // count down remaining bytes
        logic rd_start;    // read payload position zero
        logic rd_next;     // advance to next payload position
    } t_dp_cmd;

    // Datapath -> controller status.
    typedef struct packed {
        logic byte_ext;    // rx byte has the two-byte length flag
        logic len1_ok;     // one-byte length in range
        logic len2_ok;     // two-byte length in range
        logic rem_one;     // one byte left to count
        logic xor_ok;      // frame checks out with this byte
        logic rd_last;     // current result is the last of the frame
    } t_dp_sts;

endpackage

### hdl/length_prefixed_frame_deframer.sv
// Latency: the first result of a good frame is valid the cycle after its check byte is taken.
// Throughput: one input byte per cycle while a frame is received; after a good frame the
// results follow one per cycle while i_out_ready is high, and input is held off meanwhile.
// The burst rate is set by the single read port of the payload RAM.
// Reset: i_rst_n synchronous, active low; returns to waiting for a length byte, no results.
// The payload RAM has no reset; only entries written in the current frame are read.
module length_prefixed_frame_deframer import lpfd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input transaction: one received byte
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [BYTE_W-1:0] i_rx_byte,
    // output transaction: one result of an accepted frame
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [BYTE_W-1:0] o_command,
    output logic [PLEN_W-1:0] o_payload_len,
    output logic [BYTE_W-1:0] o_data_byte,
    output logic              o_data_valid,
    output logic              o_last
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Controller tracks the frame phase (length, ext length, command, payload,
    // check, result burst) and issues per-transaction commands.
    lpfd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_last      (o_last),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Datapath keeps the running XOR, length bookkeeping, command byte and
    // the payload RAM; it also forms the result fields.
    lpfd_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx_byte     (i_rx_byte),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_command     (o_command),
        .o_payload_len (o_payload_len),
        .o_data_byte   (o_data_byte),
        .o_data_valid  (o_data_valid)
    );

endmodule

### hdl/lpfd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lpfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 31
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/lpfd_dp.sv
// Datapath: length and check tracking, command capture, payload store and result fields.
module lpfd_dp import lpfd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [BYTE_W-1:0] i_rx_byte,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    output logic [BYTE_W-1:0] o_command,
    output logic [PLEN_W-1:0] o_payload_len,
    output logic [BYTE_W-1:0] o_data_byte,
    output logic              o_data_valid
);

    logic [BYTE_W-1:0] r_xor,       n_xor;
    logic [6:0]        r_len_hi,    n_len_hi;
    logic [LEN_W-1:0]  r_remaining, n_remaining;
    logic [BYTE_W-1:0] r_command,   n_command;
    logic [WP_W-1:0]   r_wr_pos,    n_wr_pos;
    logic [WP_W-1:0]   r_rd_pos,    n_rd_pos;

    logic              wr_en;
    logic              rd_en;
    logic [WP_W-1:0]   rd_addr;
    logic [BYTE_W-1:0] rd_data;
    logic              wp_zero;
    logic [WP_W:0]     rd_pos_inc;

    assign wp_zero    = (r_wr_pos == '0);
    assign rd_pos_inc = {1'b0, r_rd_pos} + (WP_W+1)'(1);

    // status
    always_comb begin
        o_sts.byte_ext  = ((i_rx_byte & LEN_EXT_MASK) != '0);
        o_sts.len1_ok   = (i_rx_byte != '0) && !o_sts.byte_ext && (i_rx_byte <= MAX_LEN_B);
        o_sts.len2_ok   = (r_len_hi == '0) && (i_rx_byte != '0) && (i_rx_byte <= MAX_LEN_B);
        o_sts.rem_one   = (r_remaining == LEN_W'(1));
        o_sts.xor_ok    = ((r_xor ^ i_rx_byte) == '0);
        o_sts.rd_last   = wp_zero || (rd_pos_inc == {1'b0, r_wr_pos});
    end

    always_comb begin
        n_xor       = r_xor;
        n_len_hi    = r_len_hi;
        n_remaining = r_remaining;
        n_command   = r_command;
        n_wr_pos    = r_wr_pos;
        n_rd_pos    = r_rd_pos;

        if (i_cmd.xor_load) begin
            n_xor = i_rx_byte;
        end else if (i_cmd.xor_acc) begin
            n_xor = r_xor ^ i_rx_byte;
        end
        if (i_cmd.hi_load) begin
            n_len_hi = 7'(i_rx_byte & LEN_LOW_MASK);
        end
        if (i_cmd.start1 || i_cmd.start2) begin
            n_remaining = LEN_W'(i_rx_byte);
            n_wr_pos    = '0;
        end else if (i_cmd.rem_dec) begin
            n_remaining = r_remaining - LEN_W'(1);
        end
        if (i_cmd.cmd_load) begin
            n_command = i_rx_byte;
        end
        if (wr_en) begin
            n_wr_pos = r_wr_pos + WP_W'(1);
        end
        if (i_cmd.rd_start) begin
            n_rd_pos = '0;
        end else if (i_cmd.rd_next) begin
            n_rd_pos = rd_pos_inc[WP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xor       <= '0;
            r_len_hi    <= '0;
            r_remaining <= '0;
            r_command   <= '0;
            r_wr_pos    <= '0;
            r_rd_pos    <= '0;
        end else begin
            r_xor       <= n_xor;
            r_len_hi    <= n_len_hi;
            r_remaining <= n_remaining;
            r_command   <= n_command;
            r_wr_pos    <= n_wr_pos;
            r_rd_pos    <= n_rd_pos;
        end
    end

    // payload store; read data registered, held between reads
    assign wr_en   = i_cmd.data_write && (r_wr_pos < WP_W'(STORE_DEPTH));
    assign rd_en   = i_cmd.rd_start || i_cmd.rd_next;
    assign rd_addr = i_cmd.rd_start ? '0 : rd_pos_inc[WP_W-1:0];

    lpfd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_wr_pos),
        .i_wdata (i_rx_byte),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign o_command     = r_command;
    assign o_payload_len = PLEN_W'(r_wr_pos);
    assign o_data_byte   = wp_zero ? '0 : rd_data;
    assign o_data_valid  = !wp_zero;

endmodule

### hdl/lpfd_ctrl.sv
// Controller: frame phase state machine, handshakes and datapath commands.
module lpfd_ctrl import lpfd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output logic    o_last,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [2:0] ST_LEN   = 3'd0;
    localparam logic [2:0] ST_LEN2  = 3'd1;
    localparam logic [2:0] ST_CMD   = 3'd2;
    localparam logic [2:0] ST_DATA  = 3'd3;
    localparam logic [2:0] ST_CHECK = 3'd4;
    localparam logic [2:0] ST_SHOW  = 3'd5;

    logic [2:0] r_state, n_state;
    logic       in_acc;
    logic       out_acc;

    assign o_in_ready  = (r_state != ST_SHOW);
    assign o_out_valid = (r_state == ST_SHOW);
    assign o_last      = i_sts.rd_last;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_acc     = o_out_valid && i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_LEN: begin
                if (in_acc) begin
                    o_cmd.xor_load = 1'b1;
                    o_cmd.hi_load  = 1'b1;
                    if (i_sts.byte_ext) begin
                        n_state = ST_LEN2;
                    end else if (i_sts.len1_ok) begin
                        o_cmd.start1 = 1'b1;
                        n_state      = ST_CMD;
                    end
                end
            end
            ST_LEN2: begin
                if (in_acc) begin
                    o_cmd.xor_acc = 1'b1;
                    if (i_sts.len2_ok) begin
                        o_cmd.start2 = 1'b1;
                        n_state      = ST_CMD;
                    end else begin
                        n_state = ST_LEN;
                    end
                end
            end
            ST_CMD: begin
                if (in_acc) begin
                    o_cmd.xor_acc  = 1'b1;
                    o_cmd.cmd_load = 1'b1;
                    o_cmd.rem_dec  = 1'b1;
                    n_state = i_sts.rem_one ? ST_CHECK : ST_DATA;
                end
            end
            ST_DATA: begin
                if (in_acc) begin
                    o_cmd.xor_acc    = 1'b1;
                    o_cmd.data_write = 1'b1;
                    o_cmd.rem_dec    = 1'b1;
                    if (i_sts.rem_one) begin
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                // keep position zero read so the first result is ready on entry
                o_cmd.rd_start = 1'b1;
                if (in_acc) begin
                    o_cmd.xor_acc = 1'b1;
                    n_state = i_sts.xor_ok ? ST_SHOW : ST_LEN;
                end
            end
            ST_SHOW: begin
                if (out_acc) begin
                    if (i_sts.rd_last) begin
                        n_state = ST_LEN;
                    end else begin
                        o_cmd.rd_next = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_LEN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LEN;
        end else begin
            r_state <= n_state;
        end
    end

    a_bad_check_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_state == ST_CHECK && !i_sts.xor_ok) |=> (r_state == ST_LEN))
        else $error("bad check byte did not drop the frame");

    a_last_ends_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_last) |=> (r_state == ST_LEN && !o_out_valid))
        else $error("results continued after last");

    a_data_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_state == ST_DATA && i_sts.rem_one) |=> (r_state == ST_CHECK))
        else $error("payload count did not end at check byte");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input taken during result burst");

endmodule
